// ===== src/rnf_pkg.sv =====
// Shared types, constants and helpers for the H.264 RTP NAL fragmenter.
package rnf_pkg;

    localparam int NAL_LENGTH_BITS = 16;
    localparam int CMP_BITS        = ((NAL_LENGTH_BITS > 16) ? NAL_LENGTH_BITS : 16) + 1;
    localparam int MAX_RESULTS     = 3;
    localparam int FIFO_DEPTH      = 4;
    localparam int PTR_BITS        = 2;
    localparam int CNT_BITS        = 3;

    localparam logic [4:0]  FU_A_TYPE         = 5'd28;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1200;

    typedef struct packed {
        logic [7:0]                 nal_byte;
        logic [NAL_LENGTH_BITS-1:0] nal_length;
        logic                       last_nal_of_frame;
        logic [31:0]                frame_duration;
    } item_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        packet_first;
        logic        packet_last;
        logic        marker;
        logic [31:0] rtp_timestamp;
    } result_t;

    // Results of one step, slot 0 leaves first.
    typedef struct packed {
        logic [1:0]                      count;
        result_t [MAX_RESULTS-1:0]       res;
    } push_t;

    function automatic result_t make_result(logic [7:0] b, logic first, logic last,
                                            logic mk, logic [31:0] ts);
        result_t r;
        r.payload_byte  = b;
        r.packet_first  = first;
        r.packet_last   = last;
        r.marker        = mk;
        r.rtp_timestamp = ts;
        return r;
    endfunction

endpackage

// ===== src/rnf_core.sv =====
// Packetizing step: NAL/fragment state and the results of one byte.
module rnf_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  rnf_pkg::item_t       item,
    input  logic [15:0]          max_payload,
    output rnf_pkg::push_t       push
);

    localparam int NLB = rnf_pkg::NAL_LENGTH_BITS;
    localparam int CW  = rnf_pkg::CMP_BITS;
    localparam int CW1 = CW + 1;

    logic [7:0]     ind_reg,   ind_next;
    logic [4:0]     otype_reg, otype_next;
    logic [NLB-1:0] pos_reg,   pos_next;
    logic [15:0]    fill_reg,  fill_next;
    logic           frag_reg,  frag_next;
    logic [31:0]    ts_reg,    ts_next;

    logic [NLB-1:0] len_eff, d, total;
    logic [15:0]    maxp;
    logic [CW-1:0]  d_w, fill_w, start_w;
    logic           endnal, final_frag, closes, mk, frag_start;
    logic [7:0]     fu_hdr;
    logic [1:0]     n;
    rnf_pkg::push_t res_c;

    always_comb begin
        len_eff    = (item.nal_length == '0) ? NLB'(1) : item.nal_length;
        maxp       = (max_payload == 16'd0) ? 16'd1 : max_payload;
        endnal     = pos_reg >= (len_eff - NLB'(1));
        d          = pos_reg - NLB'(1);
        total      = len_eff - NLB'(1);
        d_w        = CW'(d);
        fill_w     = CW'(fill_reg);
        start_w    = d_w - ((fill_w <= d_w) ? fill_w : d_w);
        final_frag = (CW1'(start_w) + CW1'(maxp)) >= CW1'(total);
        mk         = item.last_nal_of_frame & final_frag;
        closes     = ((17'(fill_reg) + 17'd1) >= 17'(maxp)) || endnal;
        frag_start = CW'(len_eff) > CW'(maxp);
        // S on the very first fragment wins over E.
        fu_hdr     = {3'b000, otype_reg};
        if (d == '0) begin
            fu_hdr[7] = 1'b1;
        end else if (final_frag) begin
            fu_hdr[6] = 1'b1;
        end
    end

    always_comb begin
        res_c      = '0;
        n          = 2'd0;
        ind_next   = ind_reg;
        otype_next = otype_reg;
        fill_next  = fill_reg;
        frag_next  = frag_reg;
        if (pos_reg == '0) begin
            frag_next = frag_start;
            fill_next = 16'd0;
            if (frag_start) begin
                // Consume the NAL header; keep F/NRI and type for the FU bytes.
                ind_next   = {item.nal_byte[7:5], rnf_pkg::FU_A_TYPE};
                otype_next = item.nal_byte[4:0];
            end else begin
                res_c.res[0] = rnf_pkg::make_result(item.nal_byte, 1'b1, endnal,
                                                    item.last_nal_of_frame, ts_reg);
                n = 2'd1;
            end
        end else if (!frag_reg) begin
            res_c.res[0] = rnf_pkg::make_result(item.nal_byte, 1'b0, endnal,
                                                item.last_nal_of_frame, ts_reg);
            n = 2'd1;
        end else begin
            if (fill_reg == 16'd0) begin
                res_c.res[0] = rnf_pkg::make_result(ind_reg, 1'b1, 1'b0, mk, ts_reg);
                res_c.res[1] = rnf_pkg::make_result(fu_hdr, 1'b0, 1'b0, mk, ts_reg);
                res_c.res[2] = rnf_pkg::make_result(item.nal_byte, 1'b0, closes, mk, ts_reg);
                n = 2'd3;
            end else begin
                res_c.res[0] = rnf_pkg::make_result(item.nal_byte, 1'b0, closes, mk, ts_reg);
                n = 2'd1;
            end
            fill_next = closes ? 16'd0 : (fill_reg + 16'd1);
        end

        ts_next = ts_reg;
        if (endnal) begin
            pos_next  = '0;
            fill_next = 16'd0;
            frag_next = 1'b0;
            if (item.last_nal_of_frame) begin
                ts_next = ts_reg + item.frame_duration;
            end
        end else begin
            pos_next = pos_reg + NLB'(1);
        end

        push       = res_c;
        push.count = fire ? n : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ind_reg   <= '0;
            otype_reg <= '0;
            pos_reg   <= '0;
            fill_reg  <= '0;
            frag_reg  <= 1'b0;
            ts_reg    <= '0;
        end else if (fire) begin
            ind_reg   <= ind_next;
            otype_reg <= otype_next;
            pos_reg   <= pos_next;
            fill_reg  <= fill_next;
            frag_reg  <= frag_next;
            ts_reg    <= ts_next;
        end
    end

    // An open fragment only exists inside a fragmented NAL.
    a_fill_in_frag: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != 16'd0) |-> frag_reg)
        else $error("fragment fill open outside fragmented NAL");

    // Fragmenting state is never held at the start of a NAL.
    a_frag_mid_nal: assert property (@(posedge aclk) disable iff (!aresetn)
        frag_reg |-> (pos_reg != '0))
        else $error("fragmenting flag set at NAL start");

endmodule

// ===== src/rnf_out_fifo.sv =====
// Small result queue: takes up to three results per cycle, releases one while m_ready is high.
module rnf_out_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  rnf_pkg::push_t   push,
    output logic             space_ok,
    output logic             m_valid,
    input  logic             m_ready,
    output rnf_pkg::result_t head
);

    localparam int PB = rnf_pkg::PTR_BITS;
    localparam int CB = rnf_pkg::CNT_BITS;

    rnf_pkg::result_t entry_reg [rnf_pkg::FIFO_DEPTH];
    logic [PB-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PB-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CB-1:0] count_reg, count_next;
    logic          pop;

    always_comb begin
        pop         = m_valid && m_ready;
        wr_ptr_next = wr_ptr_reg + PB'(push.count);
        rd_ptr_next = rd_ptr_reg + PB'(pop);
        count_next  = count_reg + CB'(push.count) - CB'(pop);
        m_valid     = count_reg != '0;
        head        = entry_reg[rd_ptr_reg];
        space_ok    = count_reg <= CB'(rnf_pkg::FIFO_DEPTH - rnf_pkg::MAX_RESULTS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < rnf_pkg::MAX_RESULTS; i++) begin
            if (2'(i) < push.count) begin
                entry_reg[wr_ptr_reg + PB'(i)] <= push.res[i];
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CB'(rnf_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> space_ok)
        else $error("results pushed without room");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count == 2'd0 && pop) |=> (count_reg == $past(count_reg) - CB'(1)))
        else $error("queue count lost a pop");

endmodule

// ===== src/h264_rtp_nal_fragmenter.sv =====
// Top level: H.264 NAL unit to RTP payload byte stream packetizer (FU-A).
//
// Feed one NAL unit one byte per transaction on the s_ channel, header byte
// first, with its length, last-NAL-of-frame flag and frame duration held
// constant across the NAL. The m_ channel returns RTP payload bytes tagged
// with packet_first / packet_last, the RTP marker and the timestamp of the
// packet. A NAL no longer than max_payload passes through as one packet whose
// marker is the last flag. A longer NAL drops its header byte and is cut into
// FU-A fragments, each led by an indicator byte (F, NRI, type 28) and an FU
// header (S on the first fragment, E on a later final one); the marker goes
// only on the final fragment of a frame's last NAL, after which the timestamp
// advances by the frame duration. Each input byte yields one result, none for
// a fragmented NAL's header, and three at the start of a fragment. The block
// takes one byte per cycle while the queue has room: a byte is held in the
// input register, then its results go into a four-entry queue that drains
// one byte per cycle while m_ready is high, so the input stalls after each
// fragment start while the two inserted header bytes drain. A byte reaches
// the output through the input register and then the queue. Write cfg_wr_data
// (max_payload, reset 1200, 0 treated as 1) only while the block is idle.
module h264_rtp_nal_fragmenter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [15:0]                          cfg_wr_data,
    // NAL byte input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_nal_byte,
    input  logic [rnf_pkg::NAL_LENGTH_BITS-1:0]  s_nal_length,
    input  logic                                 s_last_nal_of_frame,
    input  logic [31:0]                          s_frame_duration,
    // RTP payload output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [7:0]                           m_payload_byte,
    output logic                                 m_packet_first,
    output logic                                 m_packet_last,
    output logic                                 m_marker,
    output logic [31:0]                          m_rtp_timestamp
);

    logic [15:0]      max_payload_reg;
    logic             in_vld_reg;
    rnf_pkg::item_t   in_item_reg;
    logic             space_ok;
    logic             fire;
    rnf_pkg::push_t   push;
    rnf_pkg::result_t head;

    // Advance the held byte once the queue has room for a full step.
    assign fire    = in_vld_reg && space_ok;
    assign s_ready = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= rnf_pkg::MAX_PAYLOAD_RESET;
        end else if (cfg_wr_en) begin
            max_payload_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    // Hold the payload of the transaction; no reset needed.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.nal_byte          <= s_nal_byte;
            in_item_reg.nal_length        <= s_nal_length;
            in_item_reg.last_nal_of_frame <= s_last_nal_of_frame;
            in_item_reg.frame_duration    <= s_frame_duration;
        end
    end

    rnf_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .item        (in_item_reg),
        .max_payload (max_payload_reg),
        .push        (push)
    );

    rnf_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space_ok (space_ok),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .head     (head)
    );

    assign m_payload_byte  = head.payload_byte;
    assign m_packet_first  = head.packet_first;
    assign m_packet_last   = head.packet_last;
    assign m_marker        = head.marker;
    assign m_rtp_timestamp = head.rtp_timestamp;

    // A held byte that cannot advance must keep the input stalled.
    a_hold_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !space_ok) |-> !s_ready)
        else $error("input accepted while held byte is stuck");

    // The core only pushes results for a byte that is actually advancing.
    a_push_on_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> fire)
        else $error("results pushed without an advancing byte");

    // An accepted transaction is always present in the input register next cycle.
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_vld_reg)
        else $error("accepted transaction lost");

endmodule

// ===== tb/tb_h264_rtp_nal_fragmenter.sv =====
// Testbench for the H.264 RTP FU-A fragmenter: directed and random NAL streams checked byte by byte.
module tb_h264_rtp_nal_fragmenter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off for the fill-up test
    localparam int STALL_LIMIT     = 2000;  // cycles without any transaction before giving up
    localparam int DRAIN_CYCLES    = 6;     // input register plus queue, with margin
    localparam int RANDOM_ITEMS    = 60;
    localparam int PRINT_LIMIT     = 40;

    // DUT ports, inputs driven to known values from time zero
    logic                                aclk                = 1'b0;
    logic                                aresetn             = 1'b0;
    logic                                cfg_wr_en           = 1'b0;
    logic [15:0]                         cfg_wr_data         = '0;
    logic                                s_valid             = 1'b0;
    logic                                s_ready;
    logic [7:0]                          s_nal_byte          = '0;
    logic [rnf_pkg::NAL_LENGTH_BITS-1:0] s_nal_length        = '0;
    logic                                s_last_nal_of_frame = 1'b0;
    logic [31:0]                         s_frame_duration    = '0;
    logic                                m_valid;
    logic                                m_ready             = 1'b0;
    logic [7:0]                          m_payload_byte;
    logic                                m_packet_first;
    logic                                m_packet_last;
    logic                                m_marker;
    logic [31:0]                         m_rtp_timestamp;

    // Packetizer state as predicted by the testbench
    logic [15:0] pl_limit       = rnf_pkg::MAX_PAYLOAD_RESET;
    logic [7:0]  pl_indicator   = '0;
    logic [4:0]  pl_type        = '0;
    logic [15:0] pl_pos         = '0;
    logic [15:0] pl_fill        = '0;
    logic        pl_fragmenting = 1'b0;
    logic [31:0] pl_timestamp   = '0;

    // Payload bytes predicted but not yet seen on the m_ channel, oldest first
    rnf_pkg::result_t expected_bytes[$];

    // Run control and bookkeeping
    bit quiet_mode       = 1'b0;   // no random idle gaps on either side while set
    bit hold_off_request = 1'b0;   // ask the receiver for one long hold-off
    int error_count      = 0;
    int bytes_sent       = 0;
    int bytes_checked    = 0;
    int limit_writes     = 0;
    int idle_cycles      = 0;

    h264_rtp_nal_fragmenter u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_nal_byte          (s_nal_byte),
        .s_nal_length        (s_nal_length),
        .s_last_nal_of_frame (s_last_nal_of_frame),
        .s_frame_duration    (s_frame_duration),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_payload_byte      (m_payload_byte),
        .m_packet_first      (m_packet_first),
        .m_packet_last       (m_packet_last),
        .m_marker            (m_marker),
        .m_rtp_timestamp     (m_rtp_timestamp)
    );

    always #6 aclk = ~aclk;

    // Pick an idle gap: mostly none, some short, a few long.
    function automatic int pick_gap();
        int roll;
        if (quiet_mode) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Queue one predicted payload byte, stamped with the current timestamp.
    function automatic void queue_byte(logic [7:0] b, logic first, logic last, logic mk);
        rnf_pkg::result_t r;
        r.payload_byte  = b;
        r.packet_first  = first;
        r.packet_last   = last;
        r.marker        = mk;
        r.rtp_timestamp = pl_timestamp;
        expected_bytes.insert(expected_bytes.size(), r);
    endfunction

    // Advance the predicted packetizer by one accepted NAL byte.
    function automatic void predict_payload(rnf_pkg::item_t it);
        logic [16:0] limit_eff;
        logic [16:0] len;
        logic [16:0] data_idx;
        logic [16:0] total;
        logic [16:0] start;
        logic        at_end;
        logic        is_final;
        logic        mk;
        logic        closes;
        logic [7:0]  fu_hdr;
        // treat a zero limit and a zero length as one
        limit_eff = (pl_limit == 16'd0) ? 17'd1 : {1'b0, pl_limit};
        len       = (it.nal_length == '0) ? 17'd1 : 17'(it.nal_length);
        // the NAL ends at the first byte whose position reaches the current length minus one
        at_end    = {1'b0, pl_pos} >= (len - 17'd1);
        if (pl_pos == 16'd0) begin
            // header byte: decide between one packet and FU-A
            pl_fragmenting = len > limit_eff;
            pl_fill        = 16'd0;
            if (pl_fragmenting) begin
                // header is consumed, no payload byte for it
                pl_indicator = {it.nal_byte[7:5], rnf_pkg::FU_A_TYPE};
                pl_type      = it.nal_byte[4:0];
            end else begin
                queue_byte(it.nal_byte, 1'b1, at_end, it.last_nal_of_frame);
            end
        end else if (!pl_fragmenting) begin
            queue_byte(it.nal_byte, 1'b0, at_end, it.last_nal_of_frame);
        end else begin
            data_idx = {1'b0, pl_pos} - 17'd1;
            total    = len - 17'd1;
            start    = data_idx - ((pl_fill <= data_idx) ? 17'(pl_fill) : data_idx);
            // finality and closing both follow the limit in force now
            is_final = (18'(start) + 18'(limit_eff)) >= 18'(total);
            mk       = it.last_nal_of_frame && is_final;
            closes   = ((18'(pl_fill) + 18'd1) >= 18'(limit_eff)) || at_end;
            if (pl_fill == 16'd0) begin
                // S wins over E when one fragment is both first and final
                fu_hdr = {data_idx == 17'd0, (data_idx != 17'd0) && is_final, 1'b0, pl_type};
                queue_byte(pl_indicator, 1'b1, 1'b0, mk);
                queue_byte(fu_hdr, 1'b0, 1'b0, mk);
            end
            queue_byte(it.nal_byte, 1'b0, closes, mk);
            pl_fill = closes ? 16'd0 : pl_fill + 16'd1;
        end
        if (at_end) begin
            pl_pos         = 16'd0;
            pl_fill        = 16'd0;
            pl_fragmenting = 1'b0;
            if (it.last_nal_of_frame) begin
                pl_timestamp = pl_timestamp + it.frame_duration;
            end
        end else begin
            pl_pos = pl_pos + 16'd1;
        end
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_LIMIT) begin
            $display("mismatch on %s at %0t after %0d payload bytes: got %0h, expected %0h",
                     field, $time, bytes_checked, got, want);
        end
        error_count++;
    endtask

    // Offer one NAL byte, hold it until the transaction, then predict and maybe idle.
    task automatic send_byte(input logic [7:0] b, input logic [15:0] len, input logic last,
                             input logic [31:0] dur);
        rnf_pkg::item_t it;
        int             gap;
        it.nal_byte          = b;
        it.nal_length        = len;
        it.last_nal_of_frame = last;
        it.frame_duration    = dur;
        s_valid             <= 1'b1;
        s_nal_byte          <= b;
        s_nal_length        <= len;
        s_last_nal_of_frame <= last;
        s_frame_duration    <= dur;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_payload(it);
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Send a whole well-formed NAL: given header, random body, constant side fields.
    task automatic send_nal(input int len, input logic [7:0] hdr, input logic last,
                            input logic [31:0] dur);
        send_byte(hdr, 16'(len), last, dur);
        for (int i = 1; i < len; i++) begin
            send_byte(8'($urandom), 16'(len), last, dur);
        end
    endtask

    // Drop valid, wait for every predicted byte, then let a fragmented header clear.
    task automatic settle_block();
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_payload(input logic [15:0] v);
        settle_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        pl_limit = v;
        limit_writes++;
    endtask

    // Reset limit of 1200: every NAL goes out as one packet; timestamp wraps.
    task automatic test_single_packet_nals();
        send_nal(5, 8'h65, 1'b0, 32'd3000);
        send_nal(3, 8'h41, 1'b1, 32'hFFFF_FFFF);
        send_nal(1, 8'hFF, 1'b1, 32'd1);
        // zero length counts as a one-byte NAL
        send_byte(8'h00, 16'd0, 1'b1, 32'h8000_0000);
    endtask

    // FU-A: several fragments with marker on the last, and a lone first-and-final fragment.
    task automatic test_fu_a_fragments();
        write_max_payload(16'd4);
        send_nal(10, 8'hFF, 1'b1, 32'd90000);
        write_max_payload(16'd2);
        send_nal(3, 8'h00, 1'b1, 32'd3003);
    endtask

    // Zero and full-scale limits, and a limit change in the middle of a NAL.
    task automatic test_limit_extremes();
        write_max_payload(16'd0);
        send_nal(4, 8'hA7, 1'b1, 32'd1);
        write_max_payload(16'hFFFF);
        send_nal(6, 8'h5C, 1'b1, 32'd7);
        write_max_payload(16'd2);
        send_byte(8'h3E, 16'd9, 1'b1, 32'd11);
        for (int i = 1; i < 5; i++) begin
            send_byte(8'($urandom), 16'd9, 1'b1, 32'd11);
        end
        write_max_payload(16'd5);
        for (int i = 5; i < 9; i++) begin
            send_byte(8'($urandom), 16'd9, 1'b1, 32'd11);
        end
    endtask

    // Length field changing inside a NAL: full-scale start, shrink and growth.
    task automatic test_length_changes();
        send_byte(8'h9A, 16'hFFFF, 1'b0, 32'd0);
        send_byte(8'h12, 16'd2, 1'b1, 32'd5);
        send_byte(8'h21, 16'd8, 1'b0, 32'd0);
        send_byte(8'h34, 16'd8, 1'b0, 32'd0);
        send_byte(8'h56, 16'd3, 1'b0, 32'd0);
        send_byte(8'h61, 16'd7, 1'b1, 32'd9);
        send_byte(8'h62, 16'd7, 1'b1, 32'd9);
        send_byte(8'h63, 16'd12, 1'b1, 32'd9);
        for (int i = 3; i < 12; i++) begin
            send_byte(8'($urandom), 16'd12, 1'b1, 32'd9);
        end
    endtask

    // Hold the receiver off for a long stretch while the sender keeps offering bytes.
    task automatic test_output_backpressure();
        write_max_payload(16'd3);
        quiet_mode       = 1'b1;
        hold_off_request = 1'b1;
        send_nal(40, 8'h7C, 1'b1, 32'd1500);
        quiet_mode = 1'b0;
    endtask

    // Random NAL streams over several limits, mostly well formed, some broken.
    task automatic test_random_streams();
        logic [15:0] limits[6];
        int          sent;
        int          roll;
        int          len;
        limits    = '{16'd1, 16'd3, 16'd0, 16'd7, 16'hFFFF, 16'd2};
        limits[5] = 16'($urandom_range(2, 24));
        sent      = 0;
        for (int phase = 0; phase < 6; phase++) begin
            write_max_payload(limits[phase]);
            quiet_mode = (phase == 3);
            while (sent < (phase + 1) * RANDOM_ITEMS / 6) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    len = $urandom_range(1, 12);
                end else if (roll < 88) begin
                    len = $urandom_range(13, 40);
                end else begin
                    len = 0;
                end
                if (len > 0) begin
                    send_nal(len, 8'($urandom), 1'($urandom_range(0, 1)), $urandom);
                    sent += len;
                end else begin
                    // broken NAL: any length on the header, cut short on the next byte
                    send_byte(8'($urandom), 16'($urandom_range(0, 65535)),
                              1'($urandom_range(0, 1)), $urandom);
                    send_byte(8'($urandom), 16'($urandom_range(0, 2)),
                              1'($urandom_range(0, 1)), $urandom);
                    sent += 2;
                end
            end
            quiet_mode = 1'b0;
        end
    endtask

    // Receiver: random ready with gaps, plus one long hold-off on request.
    initial begin : result_sink
        int hold_left;
        int gap_left;
        hold_left = 0;
        gap_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left        = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (gap_left > 0) begin
                m_ready <= 1'b0;
                gap_left--;
            end else begin
                m_ready  <= 1'b1;
                gap_left = pick_gap();
            end
        end
    end

    // Compare each accepted payload byte with the oldest prediction, field by field.
    always @(posedge aclk) begin : payload_check
        rnf_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("payload byte with nothing expected", 32'(m_payload_byte), 0);
            end else begin
                want = expected_bytes.pop_front();
                if (m_payload_byte !== want.payload_byte) begin
                    report_mismatch("payload_byte", 32'(m_payload_byte), 32'(want.payload_byte));
                end
                if (m_packet_first !== want.packet_first) begin
                    report_mismatch("packet_first", 32'(m_packet_first), 32'(want.packet_first));
                end
                if (m_packet_last !== want.packet_last) begin
                    report_mismatch("packet_last", 32'(m_packet_last), 32'(want.packet_last));
                end
                if (m_marker !== want.marker) begin
                    report_mismatch("marker", 32'(m_marker), 32'(want.marker));
                end
                if (m_rtp_timestamp !== want.rtp_timestamp) begin
                    report_mismatch("rtp_timestamp", m_rtp_timestamp, want.rtp_timestamp);
                end
            end
            bytes_checked++;
        end
    end

    // Watchdog: give up after too many cycles with no transaction on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d bytes still expected",
                         idle_cycles, expected_bytes.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        // hold reset at the start, then release once for the whole run
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_packet_nals();
        test_fu_a_fragments();
        test_limit_extremes();
        test_length_changes();
        test_output_backpressure();
        test_random_streams();

        settle_block();
        $display("covered %0d NAL bytes in and %0d payload bytes out over %0d limit writes",
                 bytes_sent, bytes_checked, limit_writes);
        $display("single-packet and FU-A NALs, odd lengths and limits, long output stall");
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
